/* design/ostt_pkg.sv */
package ostt_pkg;

	localparam int KIND_BITS = 3;
	localparam int ID_BITS   = 32;
	localparam int DUR_BITS  = 31;
	localparam int TAG_BITS  = 32;
	localparam int STAT_BITS = 2;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_TICK   = 3'd0,
		KIND_SET    = 3'd1,
		KIND_FREE   = 3'd2,
		KIND_PAUSE  = 3'd3,
		KIND_CONT   = 3'd4,
		KIND_RESET  = 3'd5,
		KIND_RSVD6  = 3'd6,
		KIND_RSVD7  = 3'd7
	} kind_t;

	typedef enum logic [STAT_BITS-1:0] {
		STAT_OK    = 2'd0,
		STAT_NOID  = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	localparam logic [ID_BITS-1:0] FIRST_ID = 32'd100;

	// fired results per tick
	localparam int FIRE_MAX  = 16;
	localparam int CNT_BITS  = 5;

endpackage

/* design/ostt_ram.sv */
module ostt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/ordered_software_timer_table.sv */
// Ordered millisecond timer table.
// Input channel s_*: one transaction per operation. s_tuser carries the kind
// (tick, set, free, pause, continue, reset); s_tdata carries id, duration,
// periodic flag and tag. Output channel m_*: one or more result transactions
// per operation, m_tlast on the final one.
// Each operation walks the ordered list through one slot record RAM with a
// registered read and one shared elapsed-time subtractor/comparator, visiting
// each list entry in the states ST_RD, ST_EL and ST_CMP. A tick fires expired
// timers in order and re-inserts each periodic one by a further walk, and scans
// restart from the head after each fire. s_tready is high only while idle.
// Results sit in an output register; when the receiver stalls the walk pauses
// at the next result until the register frees up. Reset clears the time
// counter, valid bits and list length and sets the id counter to FIRST_ID;
// slot records are written by set before any read, so no clearing pass.
module ordered_software_timer_table #(
	parameter int SLOTS     = 16,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // target_id[31:0], duration_ms[62:32], periodic[63], user_tag[95:64]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // result_id[31:0], result_tag[63:32]
	output logic [2:0]  m_tuser,  // status[1:0], fired[2]
	output logic        m_tlast
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam int T  = TIME_BITS;
	localparam int CW = (TIME_BITS > ostt_pkg::DUR_BITS) ? TIME_BITS : ostt_pkg::DUR_BITS;

	typedef struct packed {
		logic                            running;
		logic                            periodic;
		logic [ostt_pkg::ID_BITS-1:0]    ident;
		logic [ostt_pkg::DUR_BITS-1:0]   total;
		logic [T-1:0]                    start;
		logic [T-1:0]                    pause_at;
		logic [T-1:0]                    psum;
		logic [ostt_pkg::TAG_BITS-1:0]   tag;
	} rec_t;

	typedef enum logic [1:0] {M_SCAN, M_INS, M_FIND} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_EL, ST_CMP, ST_FIRE, ST_PUT, ST_RESP, ST_TEND
	} state_t;

	state_t state_q;
	mode_t  mode_q;

	logic [T-1:0]                  now_q;
	logic [ostt_pkg::ID_BITS-1:0]  next_id_q;
	logic [SLOTS-1:0]              valid_q;
	logic [SLOTS-1:0]              done_q;
	logic [IW-1:0]                 order_q [SLOTS];
	logic [LW-1:0]                 len_q;
	logic [LW-1:0]                 p_q;
	logic [IW-1:0]                 cur_q;
	logic [ostt_pkg::CNT_BITS-1:0] cnt_q;

	ostt_pkg::kind_t               kind_q;
	logic [ostt_pkg::ID_BITS-1:0]  tid_q;
	logic [ostt_pkg::DUR_BITS-1:0] dur_q;

	logic [IW-1:0]                 ins_slot_q;
	logic [ostt_pkg::DUR_BITS-1:0] ins_t_q;
	logic                          ret_tick_q;

	rec_t                          rec_q;
	logic [T-1:0]                  el_q;

	logic [IW-1:0]                 fire_slot_q;
	logic                          fire_per_q;
	logic [ostt_pkg::DUR_BITS-1:0] fire_total_q;
	logic [ostt_pkg::ID_BITS-1:0]  fire_id_q;
	logic [ostt_pkg::TAG_BITS-1:0] fire_tag_q;

	logic                          pend_v_q;
	logic [ostt_pkg::ID_BITS-1:0]  pend_id_q;
	logic [ostt_pkg::TAG_BITS-1:0] pend_tag_q;

	ostt_pkg::stat_t               res_stat_q;
	logic [ostt_pkg::ID_BITS-1:0]  res_id_q;

	logic                          out_v_q;
	ostt_pkg::stat_t               out_stat_q;
	logic                          out_fired_q;
	logic [ostt_pkg::ID_BITS-1:0]  out_id_q;
	logic [ostt_pkg::TAG_BITS-1:0] out_tag_q;
	logic                          out_last_q;

	logic                          we_q;
	logic [IW-1:0]                 waddr_q;
	rec_t                          wdata_q;

	logic [$bits(rec_t)-1:0]       rdata;
	rec_t                          rd;
	logic [IW-1:0]                 raddr;
	logic [IW-1:0]                 free_idx;
	logic                          can_load;
	logic                          out_load;
	logic                          at_end;
	logic                          expd;
	logic [ostt_pkg::DUR_BITS-1:0] remain;

	assign rd       = rec_t'(rdata);
	assign raddr    = order_q[p_q[IW-1:0]];
	assign can_load = !out_v_q || m_tready;
	assign out_load = can_load && (((state_q == ST_FIRE) && pend_v_q) ||
		(state_q == ST_RESP) || (state_q == ST_TEND));
	assign at_end   = (p_q >= len_q);
	assign expd     = CW'(el_q) >= CW'(rec_q.total);
	assign remain   = expd ? '0 :
		ostt_pkg::DUR_BITS'(CW'(rec_q.total) - CW'(el_q));

	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	ostt_ram #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we_q),
		.waddr (waddr_q),
		.wdata (wdata_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= M_SCAN;
			now_q      <= '0;
			next_id_q  <= ostt_pkg::FIRST_ID;
			valid_q    <= '0;
			done_q     <= '0;
			len_q      <= '0;
			p_q        <= '0;
			cnt_q      <= '0;
			pend_v_q   <= 1'b0;
			ret_tick_q <= 1'b0;
			out_v_q    <= 1'b0;
			we_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q <= ostt_pkg::kind_t'(s_tuser);
						tid_q  <= s_tdata[31:0];
						dur_q  <= s_tdata[62:32];
						p_q    <= '0;
						unique case (ostt_pkg::kind_t'(s_tuser))
							ostt_pkg::KIND_TICK: begin
								now_q    <= now_q + T'(1);
								done_q   <= '0;
								cnt_q    <= '0;
								pend_v_q <= 1'b0;
								mode_q   <= M_SCAN;
								state_q  <= ST_RD;
							end
							ostt_pkg::KIND_SET: begin
								if (len_q >= LW'(SLOTS)) begin
									res_stat_q <= ostt_pkg::STAT_FULL;
									res_id_q   <= '0;
									state_q    <= ST_RESP;
								end else begin
									next_id_q         <= next_id_q + 32'd1;
									res_stat_q        <= ostt_pkg::STAT_OK;
									res_id_q          <= next_id_q + 32'd1;
									valid_q[free_idx] <= 1'b1;
									we_q              <= 1'b1;
									waddr_q           <= free_idx;
									wdata_q           <= '{running: 1'b1,
										periodic: s_tdata[63],
										ident: next_id_q + 32'd1,
										total: s_tdata[62:32],
										start: now_q,
										pause_at: now_q,
										psum: '0,
										tag: s_tdata[95:64]};
									ins_slot_q        <= free_idx;
									ins_t_q           <= s_tdata[62:32];
									ret_tick_q        <= 1'b0;
									mode_q            <= M_INS;
									state_q           <= ST_RD;
								end
							end
							ostt_pkg::KIND_FREE, ostt_pkg::KIND_PAUSE,
							ostt_pkg::KIND_CONT, ostt_pkg::KIND_RESET: begin
								mode_q  <= M_FIND;
								state_q <= ST_RD;
							end
							default: begin
								res_stat_q <= ostt_pkg::STAT_OK;
								res_id_q   <= '0;
								state_q    <= ST_RESP;
							end
						endcase
					end
				end
				ST_RD: begin
					we_q <= 1'b0;
					if (at_end) begin
						unique case (mode_q)
							M_SCAN: state_q <= ST_TEND;
							M_INS:  state_q <= ST_PUT;
							default: begin
								res_stat_q <= ostt_pkg::STAT_NOID;
								res_id_q   <= tid_q;
								state_q    <= ST_RESP;
							end
						endcase
					end else begin
						cur_q   <= raddr;
						state_q <= ST_EL;
					end
				end
				ST_EL: begin
					rec_q   <= rd;
					el_q    <= now_q - rd.start - rd.psum;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					unique case (mode_q)
						M_SCAN: begin
							if (!rec_q.running || done_q[cur_q]) begin
								p_q     <= p_q + LW'(1);
								state_q <= ST_RD;
							end else if (!expd) begin
								state_q <= ST_TEND;
							end else begin
								done_q[cur_q] <= 1'b1;
								cnt_q         <= cnt_q + ostt_pkg::CNT_BITS'(1);
								fire_slot_q   <= cur_q;
								fire_per_q    <= rec_q.periodic;
								fire_total_q  <= rec_q.total;
								fire_id_q     <= rec_q.ident;
								fire_tag_q    <= rec_q.tag;
								for (int i = 0; i < SLOTS - 1; i++) begin
									if (LW'(i) >= p_q) begin
										order_q[i] <= order_q[i+1];
									end
								end
								len_q <= len_q - LW'(1);
								if (rec_q.periodic) begin
									we_q    <= 1'b1;
									waddr_q <= cur_q;
									wdata_q <= '{running: rec_q.running,
										periodic: rec_q.periodic,
										ident: rec_q.ident,
										total: rec_q.total,
										start: now_q,
										pause_at: rec_q.pause_at,
										psum: '0,
										tag: rec_q.tag};
								end
								state_q <= ST_FIRE;
							end
						end
						M_INS: begin
							if (ins_t_q > remain) begin
								p_q     <= p_q + LW'(1);
								state_q <= ST_RD;
							end else begin
								state_q <= ST_PUT;
							end
						end
						default: begin
							if (rec_q.ident == tid_q) begin
								res_stat_q <= ostt_pkg::STAT_OK;
								res_id_q   <= tid_q;
								waddr_q    <= cur_q;
								priority case (kind_q)
									ostt_pkg::KIND_FREE: begin
										for (int i = 0; i < SLOTS - 1; i++) begin
											if (LW'(i) >= p_q) begin
												order_q[i] <= order_q[i+1];
											end
										end
										len_q          <= len_q - LW'(1);
										valid_q[cur_q] <= 1'b0;
									end
									ostt_pkg::KIND_PAUSE: begin
										we_q    <= 1'b1;
										wdata_q <= '{running: 1'b0,
											periodic: rec_q.periodic,
											ident: rec_q.ident,
											total: rec_q.total,
											start: rec_q.start,
											pause_at: now_q,
											psum: rec_q.psum,
											tag: rec_q.tag};
									end
									ostt_pkg::KIND_CONT: begin
										if (!rec_q.running) begin
											we_q    <= 1'b1;
											wdata_q <= '{running: 1'b1,
												periodic: rec_q.periodic,
												ident: rec_q.ident,
												total: rec_q.total,
												start: rec_q.start,
												pause_at: rec_q.pause_at,
												psum: rec_q.psum +
													(now_q - rec_q.pause_at),
												tag: rec_q.tag};
										end
									end
									default: begin
										we_q    <= 1'b1;
										wdata_q <= '{running: rec_q.running,
											periodic: rec_q.periodic,
											ident: rec_q.ident,
											total: dur_q,
											start: now_q,
											pause_at: rec_q.pause_at,
											psum: '0,
											tag: rec_q.tag};
									end
								endcase
								state_q <= ST_RESP;
							end else begin
								p_q     <= p_q + LW'(1);
								state_q <= ST_RD;
							end
						end
					endcase
				end
				ST_FIRE: begin
					we_q <= 1'b0;
					if (!pend_v_q || can_load) begin
						if (pend_v_q) begin
							out_stat_q  <= ostt_pkg::STAT_OK;
							out_fired_q <= 1'b1;
							out_id_q    <= pend_id_q;
							out_tag_q   <= pend_tag_q;
							out_last_q  <= 1'b0;
						end
						pend_v_q   <= 1'b1;
						pend_id_q  <= fire_id_q;
						pend_tag_q <= fire_tag_q;
						p_q        <= '0;
						if (fire_per_q) begin
							ins_slot_q <= fire_slot_q;
							ins_t_q    <= fire_total_q;
							ret_tick_q <= 1'b1;
							mode_q     <= M_INS;
							state_q    <= ST_RD;
						end else begin
							valid_q[fire_slot_q] <= 1'b0;
							mode_q               <= M_SCAN;
							state_q <= (cnt_q == ostt_pkg::CNT_BITS'(ostt_pkg::FIRE_MAX)) ?
								ST_TEND : ST_RD;
						end
					end
				end
				ST_PUT: begin
					for (int i = 1; i < SLOTS; i++) begin
						if (LW'(i) > p_q) begin
							order_q[i] <= order_q[i-1];
						end
					end
					order_q[p_q[IW-1:0]] <= ins_slot_q;
					len_q <= len_q + LW'(1);
					p_q   <= '0;
					if (ret_tick_q) begin
						mode_q  <= M_SCAN;
						state_q <= (cnt_q == ostt_pkg::CNT_BITS'(ostt_pkg::FIRE_MAX)) ?
							ST_TEND : ST_RD;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					we_q <= 1'b0;
					if (can_load) begin
						out_stat_q  <= res_stat_q;
						out_fired_q <= 1'b0;
						out_id_q    <= res_id_q;
						out_tag_q   <= '0;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					if (can_load) begin
						out_stat_q  <= ostt_pkg::STAT_OK;
						out_fired_q <= pend_v_q;
						out_id_q    <= pend_v_q ? pend_id_q : '0;
						out_tag_q   <= pend_v_q ? pend_tag_q : '0;
						out_last_q  <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_tag_q, out_id_q};
	assign m_tuser  = {out_fired_q, out_stat_q};
	assign m_tlast  = out_last_q;

endmodule

/* design/ostt_chk.sv */
module ostt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped under stall");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed under stall");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after accepted transaction");

	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tlast)
		else $error("ready while results of an operation are pending");

endmodule

bind ordered_software_timer_table ostt_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
